>>> src/sitda_pkg.sv
// Shared constants and types for the signed integer to decimal text converter.
`timescale 1ns / 1ps

package sitda_pkg;

   // ASCII character and run length widths on the result channel
   localparam int CHAR_W = 8;
   localparam int LEN_W  = 4;

   // Binary bits consumed by each shift-add-3 pipeline stage
   localparam int BITS_PER_STAGE = 4;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef logic [3:0] digit_type;

   localparam digit_type DIGIT_FIVE  = 4'd5;
   localparam digit_type DIGIT_THREE = 4'd3;

endpackage

>>> src/sitda_dabble_stage.sv
// One registered shift-add-3 stage of the binary to BCD pipeline.
`timescale 1ns / 1ps

module sitda_dabble_stage #(
   parameter int MAG_W   = 32,
   parameter int NUM_DIG = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 in_neg,
   input  logic [MAG_W-1:0]     in_mag,
   input  logic [NUM_DIG*4-1:0] in_bcd,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 out_neg,
   output logic [MAG_W-1:0]     out_mag,
   output logic [NUM_DIG*4-1:0] out_bcd
);
   import sitda_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 neg_ff;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic [NUM_DIG*4-1:0] bcd_ff, bcd_in;
   logic                 load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Correct every digit, then shift the next binary bit in, once per bit
   always_comb begin
      bcd_in = in_bcd;
      mag_in = in_mag;
      for (int s = 0; s < BITS_PER_STAGE; s++) begin
         for (int d = 0; d < NUM_DIG; d++) begin
            if (bcd_in[d*4 +: 4] >= DIGIT_FIVE) begin
               bcd_in[d*4 +: 4] = bcd_in[d*4 +: 4] + DIGIT_THREE;
            end
         end
         {bcd_in, mag_in} = {bcd_in[NUM_DIG*4-2:0], mag_in, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         neg_ff <= in_neg;
         mag_ff <= mag_in;
         bcd_ff <= bcd_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_neg   = neg_ff;
   assign out_mag   = mag_ff;
   assign out_bcd   = bcd_ff;

endmodule

>>> src/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII character stream.
`timescale 1ns / 1ps

// Each word on req_ is a two's complement integer of DATA_WIDTH bits; the
// block returns its decimal text on rsp_ as one ASCII character per word,
// most significant first: a leading '-' for negative values, no leading
// zeros, a single '0' for zero. The final character has rsp_tlast set and
// carries the character count in rsp_tuser (zero on all other characters,
// count kept to its low four bits). The most negative value converts
// correctly. Conversion runs through a pipeline of one sign stage,
// ceil(DATA_WIDTH/4) shift-add-3 stages and one digit-count stage, and
// stalls hold every stage. The character serialiser sends one character
// per cycle while rsp_tready allows; a number has 1 to 11 characters at
// 32 bits, and the next number follows with no gap.
module signed_int_to_decimal_ascii #(
   parameter int DATA_WIDTH = 32,
   localparam int IN_W = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [IN_W-1:0]               req_tdata,  // [DATA_WIDTH-1:0] value
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sitda_pkg::CHAR_W-1:0]  rsp_tdata,  // [7:0] character
   output logic                          rsp_tlast,
   output logic [sitda_pkg::LEN_W-1:0]   rsp_tuser   // [3:0] length
);
   import sitda_pkg::*;

   localparam int NUM_STG   = (DATA_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
   localparam int MAG_W     = NUM_STG * BITS_PER_STAGE;
   localparam int NUM_DIG   = ((DATA_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int BCD_W     = NUM_DIG * 4;
   localparam int DIG_IDX_W = $clog2(NUM_DIG);
   localparam int CNT_W     = $clog2(NUM_DIG + 2);

   // Pipeline links: index 0 is the sign stage, index NUM_STG the last dabble
   logic             st_valid [NUM_STG+1];
   logic             st_ready [NUM_STG+1];
   logic             st_neg   [NUM_STG+1];
   logic [MAG_W-1:0] st_mag   [NUM_STG+1];
   logic [BCD_W-1:0] st_bcd   [NUM_STG+1];

   // Sign stage
   logic                  sgn_valid_ff, sgn_valid_in;
   logic                  sgn_neg_ff;
   logic [MAG_W-1:0]      sgn_mag_ff;
   logic [DATA_WIDTH-1:0] raw;
   logic [DATA_WIDTH-1:0] mag_abs;

   assign raw        = req_tdata[DATA_WIDTH-1:0];
   assign mag_abs    = raw[DATA_WIDTH-1] ? (~raw + 1'b1) : raw;
   assign req_tready = !sgn_valid_ff || st_ready[0];
   assign sgn_valid_in = req_tready ? req_tvalid : sgn_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sgn_valid_ff <= 1'b0;
      end else begin
         sgn_valid_ff <= sgn_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sgn_neg_ff <= raw[DATA_WIDTH-1];
         sgn_mag_ff <= MAG_W'(mag_abs);
      end
   end

   assign st_valid[0] = sgn_valid_ff;
   assign st_neg[0]   = sgn_neg_ff;
   assign st_mag[0]   = sgn_mag_ff;
   assign st_bcd[0]   = '0;

   for (genvar i = 0; i < NUM_STG; i++) begin : g_dabble
      sitda_dabble_stage #(
         .MAG_W   (MAG_W),
         .NUM_DIG (NUM_DIG)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[i]),
         .in_ready  (st_ready[i]),
         .in_neg    (st_neg[i]),
         .in_mag    (st_mag[i]),
         .in_bcd    (st_bcd[i]),
         .out_valid (st_valid[i+1]),
         .out_ready (st_ready[i+1]),
         .out_neg   (st_neg[i+1]),
         .out_mag   (st_mag[i+1]),
         .out_bcd   (st_bcd[i+1])
      );
   end

   // Digit-count stage: find the top non-zero digit and the run length
   logic                 cnt_valid_ff, cnt_valid_in, cnt_ready;
   logic                 cnt_neg_ff;
   logic [BCD_W-1:0]     cnt_bcd_ff;
   logic [DIG_IDX_W-1:0] cnt_top_ff, cnt_top_in;
   logic [LEN_W-1:0]     cnt_len_ff, cnt_len_in;
   logic [CNT_W-1:0]     char_cnt;
   logic [CNT_W+LEN_W-1:0] char_cnt_ext;
   logic                 ser_ready;

   always_comb begin
      cnt_top_in = '0;
      for (int d = 0; d < NUM_DIG; d++) begin
         if (st_bcd[NUM_STG][d*4 +: 4] != '0) begin
            cnt_top_in = DIG_IDX_W'(d);
         end
      end
      char_cnt     = CNT_W'(cnt_top_in) + CNT_W'(1) + CNT_W'(st_neg[NUM_STG]);
      char_cnt_ext = {{LEN_W{1'b0}}, char_cnt};
      cnt_len_in   = char_cnt_ext[LEN_W-1:0];
   end

   assign cnt_ready         = !cnt_valid_ff || ser_ready;
   assign st_ready[NUM_STG] = cnt_ready;
   assign cnt_valid_in      = cnt_ready ? st_valid[NUM_STG] : cnt_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= 1'b0;
      end else begin
         cnt_valid_ff <= cnt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st_valid[NUM_STG] && cnt_ready) begin
         cnt_neg_ff <= st_neg[NUM_STG];
         cnt_bcd_ff <= st_bcd[NUM_STG];
         cnt_top_ff <= cnt_top_in;
         cnt_len_ff <= cnt_len_in;
      end
   end

   // Serialiser: hand out the minus sign, then digits from the top down
   logic                 ser_valid_ff, ser_valid_in;
   logic                 ser_neg_ff, ser_neg_in;
   logic [DIG_IDX_W-1:0] ser_ptr_ff, ser_ptr_in;
   logic [BCD_W-1:0]     ser_digits_ff;
   logic [LEN_W-1:0]     ser_len_ff;
   logic                 emit, emit_last, ser_load;
   digit_type            cur_digit;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   assign cur_digit = ser_digits_ff[ser_ptr_ff*4 +: 4];
   assign emit      = ser_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign emit_last = emit && !ser_neg_ff && (ser_ptr_ff == '0);
   assign ser_ready = !ser_valid_ff || emit_last;
   assign ser_load  = cnt_valid_ff && ser_ready;

   always_comb begin
      ser_valid_in = ser_valid_ff;
      ser_neg_in   = ser_neg_ff;
      ser_ptr_in   = ser_ptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_len_in   = rsp_len_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (ser_neg_ff) begin
            rsp_char_in = CHAR_MINUS;
            rsp_last_in = 1'b0;
            rsp_len_in  = '0;
            ser_neg_in  = 1'b0;
         end else begin
            rsp_char_in = CHAR_ZERO + CHAR_W'(cur_digit);
            rsp_last_in = emit_last;
            rsp_len_in  = emit_last ? ser_len_ff : '0;
            ser_ptr_in  = ser_ptr_ff - 1'b1;
            if (emit_last) begin
               ser_valid_in = 1'b0;
            end
         end
      end
      if (ser_load) begin
         ser_valid_in = 1'b1;
         ser_neg_in   = cnt_neg_ff;
         ser_ptr_in   = cnt_top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ser_valid_ff <= ser_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ser_neg_ff  <= ser_neg_in;
      ser_ptr_ff  <= ser_ptr_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_len_ff  <= rsp_len_in;
      if (ser_load) begin
         ser_digits_ff <= cnt_bcd_ff;
         ser_len_ff    <= cnt_len_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_len_ff;

   // Every character leaving is a minus sign or a decimal digit
   a_char_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == CHAR_MINUS ||
                      (rsp_tdata >= CHAR_ZERO && rsp_tdata <= CHAR_NINE)))
      else $error("character outside the decimal alphabet");

   // Length shows only on the closing character of a run
   a_len_last : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == '0)
      else $error("length set on a non-final character");

   // A minus sign never follows a character of an unfinished run
   a_minus_first : assert property (@(posedge clock) disable iff (reset)
      $past(rsp_tvalid && rsp_tready && !rsp_tlast) && rsp_tvalid
         |-> rsp_tdata != CHAR_MINUS)
      else $error("minus sign inside a run");

endmodule
